// ===== rtl/core/srtl_pkg.sv =====
// ----------------------------------------------------------------------------
// srtl_pkg
// Shared types and codes for the sorted range table: command and status
// codes, the stored entry layout, the sequencer states and the compare flags.
// ----------------------------------------------------------------------------
package srtl_pkg;

  localparam int ADDR_W   = 32;
  localparam int TAG_W    = 16;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  // One table entry as held in memory
  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] size;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Flags from the shared compare unit
  typedef struct packed {
    logic below;   // probe lies under the entry start
    logic beyond;  // probe lies at or past start + size
  } cmp_res_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_PLACE,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/core/srtl_ram.sv =====
// ----------------------------------------------------------------------------
// srtl_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module srtl_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/srtl_cmp.sv =====
// ----------------------------------------------------------------------------
// srtl_cmp
// Shared compare unit: places a probe address against one table entry.
// One subtract and two unsigned compares; used on every search step.
// ----------------------------------------------------------------------------
module srtl_cmp (
  input  logic [srtl_pkg::ADDR_W-1:0] probe,
  input  srtl_pkg::entry_t            entry,
  output srtl_pkg::cmp_res_t          res
);

  logic [srtl_pkg::ADDR_W-1:0] offset;

  // Offset wraps modulo 2^32, as the range check expects
  assign offset     = probe - entry.start;
  assign res.below  = (probe < entry.start);
  assign res.beyond = (offset >= entry.size);

endmodule

// ===== rtl/core/sorted_range_table_lookup.sv =====
// ----------------------------------------------------------------------------
// sorted_range_table_lookup
// Address range table kept in start order, with binary-search lookup.
// ----------------------------------------------------------------------------
// One command is handled at a time; cmd_ready is high only while the
// sequencer is idle, and a result may wait in the output register while the
// next command is taken. Every search step does a registered memory read of
// the middle entry in ST_READ and then a compare in ST_CMP. An insert runs
// the same search for its slot, then moves each later entry up one place,
// reading it in ST_SHIFT_RD and writing it in ST_SHIFT_WR through the
// memory's read and write ports, then writes the new entry. Clear and the
// unused command go straight to ST_DONE. The table memory has no reset;
// only the entry count is cleared.
// ----------------------------------------------------------------------------
module sorted_range_table_lookup #(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Command channel
  input  logic                                 cmd_valid,
  output logic                                 cmd_ready,
  input  logic [srtl_pkg::CMD_W-1:0]           command,
  input  logic [srtl_pkg::ADDR_W-1:0]          addr,
  input  logic [srtl_pkg::ADDR_W-1:0]          range_size,
  input  logic [srtl_pkg::TAG_W-1:0]           tag,
  // Result channel
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output logic [srtl_pkg::STATUS_W-1:0]        status,
  output logic [srtl_pkg::TAG_W-1:0]           hit_tag,
  output logic [srtl_pkg::ADDR_W-1:0]          hit_start,
  output logic [srtl_pkg::ADDR_W-1:0]          hit_size
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_ENTRIES);

  // Registers
  srtl_pkg::state_t                   state, state_next;
  logic [CW-1:0]                      count, count_next;
  logic [CW-1:0]                      lo, lo_next;
  logic [CW-1:0]                      hi, hi_next;
  logic [CW-1:0]                      idx, idx_next;
  logic [srtl_pkg::CMD_W-1:0]         cmd_q, cmd_q_next;
  logic [srtl_pkg::ADDR_W-1:0]        addr_q, addr_q_next;
  logic [srtl_pkg::ADDR_W-1:0]        size_q, size_q_next;
  logic [srtl_pkg::TAG_W-1:0]         tag_q, tag_q_next;
  logic [srtl_pkg::STATUS_W-1:0]      status_q, status_q_next;
  srtl_pkg::entry_t                   hit_q, hit_q_next;
  logic                               res_valid_next;
  logic [srtl_pkg::STATUS_W-1:0]      status_next;
  logic [srtl_pkg::TAG_W-1:0]         hit_tag_next;
  logic [srtl_pkg::ADDR_W-1:0]        hit_start_next;
  logic [srtl_pkg::ADDR_W-1:0]        hit_size_next;

  // Datapath
  logic [CW-1:0]                      mid;
  logic [CW-1:0]                      idx_dec;
  logic                               ram_we;
  logic [AW-1:0]                      ram_waddr;
  srtl_pkg::entry_t                   ram_wdata;
  logic                               ram_re;
  logic [AW-1:0]                      ram_raddr;
  srtl_pkg::entry_t                   ram_rdata;
  srtl_pkg::cmp_res_t                 cmp;

  // Search midpoint and shift pointer
  assign mid     = lo + ((hi - lo) >> 1);
  assign idx_dec = idx - CW'(1);

  // Entry memory
  srtl_ram #(
    .WIDTH (srtl_pkg::ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Shared compare unit
  srtl_cmp u_cmp (
    .probe (addr_q),
    .entry (ram_rdata),
    .res   (cmp)
  );

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= srtl_pkg::ST_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      res_valid <= res_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    lo        <= lo_next;
    hi        <= hi_next;
    idx       <= idx_next;
    cmd_q     <= cmd_q_next;
    addr_q    <= addr_q_next;
    size_q    <= size_q_next;
    tag_q     <= tag_q_next;
    status_q  <= status_q_next;
    hit_q     <= hit_q_next;
    status    <= status_next;
    hit_tag   <= hit_tag_next;
    hit_start <= hit_start_next;
    hit_size  <= hit_size_next;
  end

  // Sequencer
  always_comb begin
    state_next     = state;
    count_next     = count;
    lo_next        = lo;
    hi_next        = hi;
    idx_next       = idx;
    cmd_q_next     = cmd_q;
    addr_q_next    = addr_q;
    size_q_next    = size_q;
    tag_q_next     = tag_q;
    status_q_next  = status_q;
    hit_q_next     = hit_q;
    res_valid_next = res_valid;
    status_next    = status;
    hit_tag_next   = hit_tag;
    hit_start_next = hit_start;
    hit_size_next  = hit_size;
    cmd_ready      = 1'b0;
    ram_re         = 1'b0;
    ram_raddr      = mid[AW-1:0];
    ram_we         = 1'b0;
    ram_waddr      = idx[AW-1:0];
    ram_wdata      = ram_rdata;

    // Output register drains on a completed transaction
    if (res_valid && res_ready) begin
      res_valid_next = 1'b0;
    end

    case (state)
      srtl_pkg::ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          cmd_q_next    = command;
          addr_q_next   = addr;
          size_q_next   = range_size;
          tag_q_next    = tag;
          status_q_next = srtl_pkg::STATUS_OK;
          hit_q_next    = '0;
          lo_next       = '0;
          hi_next       = count;
          case (command)
            srtl_pkg::CMD_CLEAR: begin
              count_next = '0;
              state_next = srtl_pkg::ST_DONE;
            end
            srtl_pkg::CMD_INSERT: begin
              if (count == COUNT_MAX) begin
                status_q_next = srtl_pkg::STATUS_FULL;
                state_next    = srtl_pkg::ST_DONE;
              end else begin
                state_next = srtl_pkg::ST_READ;
              end
            end
            srtl_pkg::CMD_LOOKUP: begin
              state_next = srtl_pkg::ST_READ;
            end
            default: begin
              state_next = srtl_pkg::ST_DONE;
            end
          endcase
        end
      end

      // Fetch the middle entry, or finish the search when the window is empty
      srtl_pkg::ST_READ: begin
        if (lo < hi) begin
          ram_re     = 1'b1;
          idx_next   = mid;
          state_next = srtl_pkg::ST_CMP;
        end else if (cmd_q == srtl_pkg::CMD_LOOKUP) begin
          status_q_next = srtl_pkg::STATUS_MISS;
          state_next    = srtl_pkg::ST_DONE;
        end else begin
          // Insert slot found at lo; open it by moving later entries up
          idx_next = count;
          if (count > lo) begin
            state_next = srtl_pkg::ST_SHIFT_RD;
          end else begin
            state_next = srtl_pkg::ST_PLACE;
          end
        end
      end

      // Narrow the window; a lookup stops on a containing range
      srtl_pkg::ST_CMP: begin
        if (cmp.below) begin
          hi_next    = idx;
          state_next = srtl_pkg::ST_READ;
        end else if (cmd_q == srtl_pkg::CMD_LOOKUP && !cmp.beyond) begin
          hit_q_next = ram_rdata;
          state_next = srtl_pkg::ST_DONE;
        end else begin
          lo_next    = idx + CW'(1);
          state_next = srtl_pkg::ST_READ;
        end
      end

      srtl_pkg::ST_SHIFT_RD: begin
        ram_re     = 1'b1;
        ram_raddr  = idx_dec[AW-1:0];
        state_next = srtl_pkg::ST_SHIFT_WR;
      end

      srtl_pkg::ST_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx[AW-1:0];
        ram_wdata = ram_rdata;
        idx_next  = idx_dec;
        if (idx_dec > lo) begin
          state_next = srtl_pkg::ST_SHIFT_RD;
        end else begin
          state_next = srtl_pkg::ST_PLACE;
        end
      end

      srtl_pkg::ST_PLACE: begin
        ram_we          = 1'b1;
        ram_waddr       = lo[AW-1:0];
        ram_wdata.start = addr_q;
        ram_wdata.size  = size_q;
        ram_wdata.tag   = tag_q;
        count_next      = count + CW'(1);
        state_next      = srtl_pkg::ST_DONE;
      end

      // Hand the result over once the output register is free
      srtl_pkg::ST_DONE: begin
        if (!res_valid || res_ready) begin
          res_valid_next = 1'b1;
          status_next    = status_q;
          hit_tag_next   = hit_q.tag;
          hit_start_next = hit_q.start;
          hit_size_next  = hit_q.size;
          state_next     = srtl_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = srtl_pkg::ST_IDLE;
      end
    endcase
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_MAX)
    else $error("entry count above table depth");

  a_window_order: assert property (@(posedge clk) disable iff (rst)
    (state == srtl_pkg::ST_READ) |-> (lo <= hi && hi <= count))
    else $error("search window out of order");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready && command == srtl_pkg::CMD_CLEAR) |=> (count == '0))
    else $error("clear left entries in the table");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (state != srtl_pkg::ST_PLACE && !(state == srtl_pkg::ST_IDLE && cmd_valid))
      |=> $stable(count))
    else $error("entry count changed outside insert or clear");

endmodule
